// ===== design/zctd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctd_pkg
// Shared types, constants and the punctuation table of the text decoder.
// ----------------------------------------------------------------------------
package zctd_pkg;

  localparam int WORD_W     = 16;
  localparam int CODE_W     = 5;
  localparam int NUM_LANES  = 3;
  localparam int END_BIT    = 15;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 16;
  localparam int VERSION_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_W     = $clog2(NUM_LANES);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ABBREV_BASE = 2'd1;

  localparam logic [VERSION_W-1:0] VERSION_RESET      = 4'd3;
  localparam logic [VERSION_W-1:0] ABBREV_MIN_VERSION = 4'd3;
  localparam logic [ADDR_W-1:0]    ABBREV_BASE_RESET  = 16'h0000;

  localparam logic [CODE_W-1:0] SPACE_CODE      = 5'd0;
  localparam logic [CODE_W-1:0] ABBREV_CODE_LO  = 5'd1;
  localparam logic [CODE_W-1:0] ABBREV_CODE_HI  = 5'd3;
  localparam logic [CODE_W-1:0] FIRST_CHAR_CODE = 5'd6;
  localparam logic [CODE_W-1:0] ESCAPE_CODE     = 5'd6;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_ABBREV = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ABBREV = 2'd1,
    ST_ESC_HI = 2'd2,
    ST_ESC_LO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_LOWER = 2'd0,
    SH_UPPER = 2'd1,
    SH_PUNCT = 2'd2
  } shift_t;

  typedef struct packed {
    status_t             status;
    shift_t              shift;
    logic [CODE_W-1:0]   prev;
  } dec_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   ch;
    logic [ADDR_W-1:0]   addr;
  } res_t;

  localparam dec_state_t STATE_RESET = '{status: ST_NORMAL, shift: SH_LOWER, prev: '0};

  // Punctuation set, indexed by code minus six.
  function automatic logic [CHAR_W-1:0] punct_char(input logic [CODE_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    case (idx)
      5'd0:    ch = 8'h20; // space
      5'd1:    ch = 8'h5E; // caret, given literally
      5'd2:    ch = 8'h30;
      5'd3:    ch = 8'h31;
      5'd4:    ch = 8'h32;
      5'd5:    ch = 8'h33;
      5'd6:    ch = 8'h34;
      5'd7:    ch = 8'h35;
      5'd8:    ch = 8'h36;
      5'd9:    ch = 8'h37;
      5'd10:   ch = 8'h38;
      5'd11:   ch = 8'h39;
      5'd12:   ch = 8'h2E;
      5'd13:   ch = 8'h2C;
      5'd14:   ch = 8'h21;
      5'd15:   ch = 8'h3F;
      5'd16:   ch = 8'h5F;
      5'd17:   ch = 8'h23;
      5'd18:   ch = 8'h27;
      5'd19:   ch = 8'h22;
      5'd20:   ch = 8'h2F;
      5'd21:   ch = 8'h5C;
      5'd22:   ch = 8'h2D;
      5'd23:   ch = 8'h3A;
      5'd24:   ch = 8'h28;
      5'd25:   ch = 8'h29;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/zchar_text_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zchar_text_decoder_unit
// Text word decoder: three code lanes and a result serializer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_text_word) takes one 16-bit
//   encoded word per transfer. Each word yields exactly three results on the
//   output channel (out_valid / out_stall and the out_ fields), one per
//   transfer, most significant code first; out_last_of_word marks the third,
//   and out_string_ended is set on it when the word's end bit was set.
//   Latency: the first result of a word is offered the cycle after the word
//   transfers, the other two follow on the next cycles when not stalled.
//   The single-result output channel paces the input: the three lanes decode a
//   whole word in the cycle it transfers, and the next word is taken in the
//   same cycle as the last result of the previous word leaves.
//   A stall on the output holds the current result and stalls the input.
//   Reset (rst_n low, synchronous) empties the result buffer, clears the
//   decode state and sets story_version to 3 and abbrev_table_base to 0.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
//   and belong to times when no word is in flight.
// ----------------------------------------------------------------------------
module zchar_text_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [zctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zctd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [zctd_pkg::WORD_W-1:0]     in_text_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_result_kind,
  output logic [zctd_pkg::CHAR_W-1:0]     out_char_code,
  output logic [zctd_pkg::ADDR_W-1:0]     out_abbrev_pointer_addr,
  output logic                            out_last_of_word,
  output logic                            out_string_ended
);

  logic [zctd_pkg::VERSION_W-1:0] version_r;
  logic [zctd_pkg::ADDR_W-1:0]    abbrev_base_r;
  zctd_pkg::dec_state_t           state_r, state_nxt;
  zctd_pkg::dec_state_t           lane_st [zctd_pkg::NUM_LANES+1];
  zctd_pkg::res_t                 lane_res [zctd_pkg::NUM_LANES];
  zctd_pkg::res_t                 out_res;
  logic                           word_end;
  logic                           take;

  assign word_end = in_text_word[zctd_pkg::END_BIT];
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r     <= zctd_pkg::VERSION_RESET;
      abbrev_base_r <= zctd_pkg::ABBREV_BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        zctd_pkg::CFG_IDX_VERSION:     version_r <= cfg_wdata[zctd_pkg::VERSION_W-1:0];
        zctd_pkg::CFG_IDX_ABBREV_BASE: abbrev_base_r <= cfg_wdata[zctd_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign lane_st[0] = state_r;

  for (genvar k = 0; k < zctd_pkg::NUM_LANES; k++) begin : g_lane
    zctd_lane u_lane (
      .code              (in_text_word[zctd_pkg::CODE_W*(zctd_pkg::NUM_LANES-1-k) +:
                                       zctd_pkg::CODE_W]),
      .st_in             (lane_st[k]),
      .story_version     (version_r),
      .abbrev_table_base (abbrev_base_r),
      .res               (lane_res[k]),
      .st_out            (lane_st[k+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      state_nxt = word_end ? zctd_pkg::STATE_RESET : lane_st[zctd_pkg::NUM_LANES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zctd_pkg::STATE_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  zctd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_res  (lane_res),
    .word_end  (word_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .out_last  (out_last_of_word),
    .out_end   (out_string_ended)
  );

  assign out_result_kind         = out_res.kind;
  assign out_char_code           = out_res.ch;
  assign out_abbrev_pointer_addr = out_res.addr;

`ifndef SYNTHESIS
  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (take && word_end) |=> (state_r == zctd_pkg::STATE_RESET))
    else $error("string end did not clear the decode state");

  a_prev_is_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !word_end) |=> (state_r.prev == $past(in_text_word[zctd_pkg::CODE_W-1:0])))
    else $error("previous code does not match the last code of the word");
`endif

endmodule

// ===== design/zctd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctd_lane
// Decodes one 5-bit code against the incoming decode state and produces one
// result together with the state handed to the next code.
// ----------------------------------------------------------------------------
module zctd_lane (
  input  logic [zctd_pkg::CODE_W-1:0]    code,
  input  zctd_pkg::dec_state_t           st_in,
  input  logic [zctd_pkg::VERSION_W-1:0] story_version,
  input  logic [zctd_pkg::ADDR_W-1:0]    abbrev_table_base,
  output zctd_pkg::res_t                 res,
  output zctd_pkg::dec_state_t           st_out
);

  logic [zctd_pkg::CODE_W-1:0] idx;
  logic [zctd_pkg::CHAR_W-1:0] set_char;
  logic [zctd_pkg::ADDR_W-1:0] row_off;
  logic [zctd_pkg::ADDR_W-1:0] col_off;
  logic                        abbrev_on;

  assign idx       = code - zctd_pkg::FIRST_CHAR_CODE;
  assign abbrev_on = (story_version >= zctd_pkg::ABBREV_MIN_VERSION);

  // Each abbreviation bank spans 32 pointer words; the address wraps at 16 bits.
  assign row_off = (zctd_pkg::ADDR_W'(st_in.prev) - zctd_pkg::ADDR_W'(1)) << 6;
  assign col_off = zctd_pkg::ADDR_W'(code) << 1;

  always_comb begin
    case (st_in.shift)
      zctd_pkg::SH_LOWER: set_char = zctd_pkg::CHAR_LOWER_A + zctd_pkg::CHAR_W'(idx);
      zctd_pkg::SH_UPPER: set_char = zctd_pkg::CHAR_UPPER_A + zctd_pkg::CHAR_W'(idx);
      default:            set_char = zctd_pkg::punct_char(idx);
    endcase
  end

  always_comb begin
    res         = '{kind: zctd_pkg::KIND_NONE, ch: '0, addr: '0};
    st_out      = st_in;
    st_out.prev = code;
    case (st_in.status)
      zctd_pkg::ST_NORMAL: begin
        if (st_in.shift == zctd_pkg::SH_PUNCT && code == zctd_pkg::ESCAPE_CODE) begin
          st_out.status = zctd_pkg::ST_ESC_HI;
          st_out.shift  = zctd_pkg::SH_LOWER;
        end else if (code >= zctd_pkg::FIRST_CHAR_CODE) begin
          res.kind     = zctd_pkg::KIND_CHAR;
          res.ch       = set_char;
          st_out.shift = zctd_pkg::SH_LOWER;
        end else if (code == zctd_pkg::SPACE_CODE) begin
          res.kind     = zctd_pkg::KIND_CHAR;
          res.ch       = zctd_pkg::CHAR_SPACE;
          st_out.shift = zctd_pkg::SH_LOWER;
        end else if (abbrev_on &&
                     (code inside {[zctd_pkg::ABBREV_CODE_LO:zctd_pkg::ABBREV_CODE_HI]})) begin
          st_out.status = zctd_pkg::ST_ABBREV;
          st_out.shift  = zctd_pkg::SH_LOWER;
        end else begin
          // One-code shift: odd codes pick punctuation, even codes upper case.
          st_out.shift = code[0] ? zctd_pkg::SH_PUNCT : zctd_pkg::SH_UPPER;
        end
      end
      zctd_pkg::ST_ABBREV: begin
        res.kind      = zctd_pkg::KIND_ABBREV;
        res.addr      = abbrev_table_base + row_off + col_off;
        st_out.status = zctd_pkg::ST_NORMAL;
      end
      zctd_pkg::ST_ESC_HI: begin
        st_out.status = zctd_pkg::ST_ESC_LO;
      end
      default: begin
        // Low part of the escape; the 10-bit value keeps its low 8 bits.
        res.kind      = zctd_pkg::KIND_CHAR;
        res.ch        = {st_in.prev[2:0], code};
        st_out.status = zctd_pkg::ST_NORMAL;
      end
    endcase
  end

endmodule

// ===== design/zctd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zctd_merge
// Holds the three lane results of one word and sends them out one transfer
// at a time, marking the last one of the word.
// ----------------------------------------------------------------------------
module zctd_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  zctd_pkg::res_t                 lane_res [zctd_pkg::NUM_LANES],
  input  logic                           word_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output zctd_pkg::res_t                 out_res,
  output logic                           out_last,
  output logic                           out_end
);

  localparam logic [zctd_pkg::SLOT_W-1:0] LAST_SLOT = zctd_pkg::SLOT_W'(zctd_pkg::NUM_LANES - 1);

  logic                          valid_r, valid_nxt;
  logic [zctd_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  zctd_pkg::res_t                res_r [zctd_pkg::NUM_LANES];
  logic                          end_r;
  logic                          take;
  logic                          send;

  // A new word loads while the final result of the previous one transfers.
  assign in_stall = valid_r && !(slot_r == LAST_SLOT && !out_stall);
  assign take     = in_valid && !in_stall;
  assign send     = valid_r && !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    slot_nxt  = slot_r;
    if (take) begin
      valid_nxt = 1'b1;
      slot_nxt  = '0;
    end else if (send) begin
      if (slot_r == LAST_SLOT) begin
        valid_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + zctd_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= lane_res;
      end_r <= word_end;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r[slot_r];
  assign out_last  = (slot_r == LAST_SLOT);
  assign out_end   = (slot_r == LAST_SLOT) && end_r;

`ifndef SYNTHESIS
  a_load_starts_first_slot: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (valid_r && slot_r == '0))
    else $error("word load did not restart at the first result");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (slot_r <= LAST_SLOT))
    else $error("result slot beyond the last lane");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && $stable(slot_r)))
    else $error("result slot moved while the receiver stalled");
`endif

endmodule
